// ===== hdl/cba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and codes of the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

	localparam int DISK_BLOCKS_DEF = 256;
	localparam int DIR_ENTRIES_DEF = 256;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_MODIFY = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOSPACE  = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_DIRFULL  = 3'd3;
	localparam logic [2:0] ST_DUP      = 3'd4;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] file_name;
		logic [7:0] block_count;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] start_block;
		logic [7:0] length_blocks;
	} rsp_t;

endpackage

// ===== hdl/contiguous_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// a request walks the n directory entries in use before it is dispatched; a growing modify
// frees the old run, scans the free map, then writes the new run or restores the old one,
// one memory entry per cycle in each pass
// throughput: one request at a time; the next is taken once the result sits in the output register
// reset: after arst_n a clearing pass over all DISK_BLOCKS entries fills the free map, req_ready low
// ----------------------------------------------------------------------------
// contiguous_block_allocator_unit
// First-fit contiguous block allocator with a block free map and an
// append-only file directory, both held in synchronous memories.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_unit #(
	parameter int DISK_BLOCKS = cba_pkg::DISK_BLOCKS_DEF,
	parameter int DIR_ENTRIES = cba_pkg::DIR_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cba_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cba_pkg::rsp_t rsp
);

	localparam int BW = $clog2(DISK_BLOCKS);
	localparam int EW = $clog2(DIR_ENTRIES);
	localparam int AW = BW + 9;

	typedef struct packed {
		logic          live;
		logic [7:0]    name;
		logic [7:0]    size;
		logic [BW-1:0] start;
	} dir_entry_t;

	// sequencer states
	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_DISP  = 3'd3;
	localparam logic [2:0] S_RUN   = 3'd4;
	localparam logic [2:0] S_FIND  = 3'd5;
	localparam logic [2:0] S_WRDIR = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	// purpose of a run write over the free map
	localparam logic [2:0] RK_DEL     = 3'd0;
	localparam logic [2:0] RK_TRUNC   = 3'd1;
	localparam logic [2:0] RK_FREE    = 3'd2;
	localparam logic [2:0] RK_ALLOC   = 3'd3;
	localparam logic [2:0] RK_RESTORE = 3'd4;

	logic [2:0]    state_q;

	// latched request
	logic [1:0]    op_q;
	logic [7:0]    name_q;
	logic [7:0]    cnt_q;

	// directory walk
	logic [EW:0]   count_q;
	logic [EW:0]   li_q;
	logic          look_pend_s1;
	logic [EW-1:0] look_idx_s1;
	logic          found_q;
	logic [EW-1:0] k_q;
	logic [BW-1:0] os_q;
	logic [7:0]    ol_q;

	// free-map scan, also the clearing pass counter
	logic [BW:0]   fi_q;
	logic          find_pend_s1;
	logic [BW-1:0] faddr_s1;
	logic [7:0]    frun_q;
	logic [AW-1:0] where_calc;

	// run write
	logic [AW-1:0] run_base_q;
	logic [7:0]    run_len_q;
	logic [7:0]    run_j_q;
	logic          run_set_q;
	logic [2:0]    run_kind_q;
	logic [AW-1:0] run_addr;

	// result
	logic [2:0]    res_status_q;
	logic [BW-1:0] where_q;
	logic [7:0]    res_len_q;
	logic          rsp_valid_q;
	cba_pkg::rsp_t rsp_q;

	// memories
	logic          used_mem [DISK_BLOCKS];
	logic          used_we;
	logic [BW-1:0] used_waddr;
	logic          used_wdata;
	logic          used_rdata_q;
	dir_entry_t    dir_mem [DIR_ENTRIES];
	logic          dir_we;
	logic [EW-1:0] dir_waddr;
	dir_entry_t    dir_wdata;
	dir_entry_t    dir_rdata_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign run_addr   = run_base_q + AW'(run_j_q);
	assign where_calc = AW'(faddr_s1) + AW'(1) - AW'(cnt_q);

	// free-map port: clearing pass or run write
	always_comb begin
		used_we    = 1'b0;
		used_waddr = run_addr[BW-1:0];
		used_wdata = run_set_q;
		if (state_q == S_INIT) begin
			used_we    = 1'b1;
			used_waddr = fi_q[BW-1:0];
			used_wdata = (fi_q == '0);
		end else if (state_q == S_RUN && run_j_q != run_len_q
				&& run_addr < AW'(DISK_BLOCKS)) begin
			used_we = 1'b1;
		end
	end

	// directory write: append on create, update in place otherwise
	always_comb begin
		dir_we          = (state_q == S_WRDIR);
		dir_waddr       = (op_q == cba_pkg::OP_CREATE) ? count_q[EW-1:0] : k_q;
		dir_wdata.live  = (op_q != cba_pkg::OP_DELETE);
		dir_wdata.name  = name_q;
		dir_wdata.size  = (op_q == cba_pkg::OP_DELETE) ? 8'd0 : cnt_q;
		dir_wdata.start = where_q;
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_waddr] <= used_wdata;
		end
		used_rdata_q <= used_mem[fi_q[BW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		dir_rdata_q <= dir_mem[li_q[EW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= req.opcode;
				name_q <= req.file_name;
				cnt_q  <= req.block_count;
			end
			S_LOOK: begin
				look_idx_s1 <= li_q[EW-1:0];
				if (look_pend_s1 && dir_rdata_q.live && dir_rdata_q.name == name_q) begin
					k_q  <= look_idx_s1;
					os_q <= dir_rdata_q.start;
					ol_q <= dir_rdata_q.size;
				end
			end
			S_FIND: begin
				faddr_s1 <= fi_q[BW-1:0];
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.status        <= res_status_q;
					rsp_q.start_block   <= 8'(where_q);
					rsp_q.length_blocks <= res_len_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			fi_q         <= '0;
			count_q      <= '0;
			li_q         <= '0;
			look_pend_s1 <= 1'b0;
			found_q      <= 1'b0;
			find_pend_s1 <= 1'b0;
			frun_q       <= '0;
			run_base_q   <= '0;
			run_len_q    <= '0;
			run_j_q      <= '0;
			run_set_q    <= 1'b0;
			run_kind_q   <= RK_DEL;
			res_status_q <= cba_pkg::ST_OK;
			where_q      <= '0;
			res_len_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// output register: loaded from the done state, cleared by its transfer
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					// clearing pass: every block free but block zero
					fi_q <= fi_q + 1'b1;
					if (fi_q == (BW+1)'(DISK_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						li_q         <= '0;
						look_pend_s1 <= 1'b0;
						found_q      <= 1'b0;
						state_q      <= S_LOOK;
					end
				end
				S_LOOK: begin
					// one directory read issued per cycle, compared in the next cycle
					if (li_q < count_q) begin
						li_q         <= li_q + 1'b1;
						look_pend_s1 <= 1'b1;
					end else begin
						look_pend_s1 <= 1'b0;
					end
					if (look_pend_s1 && dir_rdata_q.live && dir_rdata_q.name == name_q) begin
						found_q <= 1'b1;
						state_q <= S_DISP;
					end else if (!look_pend_s1 && li_q == count_q) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					// query reports the entry, a shrink keeps its start, all else starts at zero
					where_q   <= (found_q && (op_q == cba_pkg::OP_QUERY
						|| (op_q == cba_pkg::OP_MODIFY && cnt_q <= ol_q))) ? os_q : '0;
					res_len_q <= (found_q && op_q == cba_pkg::OP_QUERY) ? ol_q : '0;
					fi_q      <= '0;
					frun_q    <= '0;
					find_pend_s1 <= 1'b0;
					run_j_q   <= '0;
					if (op_q == cba_pkg::OP_CREATE) begin
						if (found_q) begin
							res_status_q <= cba_pkg::ST_DUP;
							state_q      <= S_DONE;
						end else if (count_q == (EW+1)'(DIR_ENTRIES)) begin
							res_status_q <= cba_pkg::ST_DIRFULL;
							state_q      <= S_DONE;
						end else if (cnt_q == 8'd0) begin
							// empty file takes no blocks
							res_status_q <= cba_pkg::ST_OK;
							state_q      <= S_WRDIR;
						end else begin
							state_q <= S_FIND;
						end
					end else if (!found_q) begin
						res_status_q <= cba_pkg::ST_NOTFOUND;
						state_q      <= S_DONE;
					end else if (op_q == cba_pkg::OP_QUERY) begin
						res_status_q <= cba_pkg::ST_OK;
						state_q      <= S_DONE;
					end else if (op_q == cba_pkg::OP_DELETE) begin
						run_base_q <= AW'(os_q);
						run_len_q  <= ol_q;
						run_set_q  <= 1'b0;
						run_kind_q <= RK_DEL;
						state_q    <= S_RUN;
					end else if (cnt_q <= ol_q) begin
						// shrink in place, free the tail
						run_base_q <= AW'(os_q) + AW'(cnt_q);
						run_len_q  <= ol_q - cnt_q;
						run_set_q  <= 1'b0;
						run_kind_q <= RK_TRUNC;
						state_q    <= S_RUN;
					end else begin
						// grow: give back the old run before the search
						run_base_q <= AW'(os_q);
						run_len_q  <= ol_q;
						run_set_q  <= 1'b0;
						run_kind_q <= RK_FREE;
						state_q    <= S_RUN;
					end
				end
				S_RUN: begin
					if (run_j_q != run_len_q) begin
						run_j_q <= run_j_q + 1'b1;
					end else begin
						run_j_q <= '0;
						case (run_kind_q)
							RK_DEL, RK_TRUNC, RK_ALLOC: begin
								res_status_q <= cba_pkg::ST_OK;
								state_q      <= S_WRDIR;
							end
							RK_FREE: begin
								fi_q         <= '0;
								frun_q       <= '0;
								find_pend_s1 <= 1'b0;
								state_q      <= S_FIND;
							end
							default: begin
								res_status_q <= cba_pkg::ST_NOSPACE;
								where_q      <= '0;
								res_len_q    <= '0;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_FIND: begin
					// first-fit scan, one block read per cycle
					if (fi_q < (BW+1)'(DISK_BLOCKS)) begin
						fi_q         <= fi_q + 1'b1;
						find_pend_s1 <= 1'b1;
					end else begin
						find_pend_s1 <= 1'b0;
					end
					if (find_pend_s1) begin
						if (used_rdata_q) begin
							frun_q <= '0;
						end else begin
							frun_q <= frun_q + 1'b1;
						end
					end
					if (find_pend_s1 && !used_rdata_q && (9'(frun_q) + 9'd1) == 9'(cnt_q)) begin
						where_q    <= where_calc[BW-1:0];
						run_base_q <= where_calc;
						run_len_q  <= cnt_q;
						run_set_q  <= 1'b1;
						run_kind_q <= RK_ALLOC;
						run_j_q    <= '0;
						state_q    <= S_RUN;
					end else if (!find_pend_s1 && fi_q == (BW+1)'(DISK_BLOCKS)) begin
						if (op_q == cba_pkg::OP_CREATE) begin
							res_status_q <= cba_pkg::ST_NOSPACE;
							res_len_q    <= '0;
							where_q      <= '0;
							state_q      <= S_DONE;
						end else begin
							// no fit: take the old run back
							run_base_q <= AW'(os_q);
							run_len_q  <= ol_q;
							run_set_q  <= 1'b1;
							run_kind_q <= RK_RESTORE;
							run_j_q    <= '0;
							state_q    <= S_RUN;
						end
					end
				end
				S_WRDIR: begin
					res_len_q <= (op_q == cba_pkg::OP_DELETE) ? 8'd0 : cnt_q;
					if (op_q == cba_pkg::OP_CREATE) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an accepted request always leaves the idle state
	a_req_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q != S_IDLE)
		else $error("request transfer did not start the sequencer");

	// directory fill never passes its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (EW+1)'(DIR_ENTRIES))
		else $error("directory fill count overflow");

	// error results carry no location
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != cba_pkg::ST_OK
		|-> rsp.start_block == 8'd0 && rsp.length_blocks == 8'd0)
		else $error("error result with nonzero location");

	// a new result is loaded only when the previous one has gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> rsp_valid_q && $stable(rsp_q))
		else $error("pending result overwritten");

endmodule

// ===== tb/contiguous_block_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator_unit_test
// Self-checking bench for the first-fit block allocator: a short table of
// directed requests, then random create, modify, delete and query traffic
// under several idling patterns, each response checked against its table entry or a
// behavioral copy of the free map and the file directory.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_unit_test;

	localparam int NUM_BLOCKS  = cba_pkg::DISK_BLOCKS_DEF;
	localparam int NUM_ENTRIES = cba_pkg::DIR_ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int TAIL_CYCLES = 1200;
	localparam int HOLD_CYCLES = 3000;
	localparam int PHASE_ITEMS = 250;

	logic          clk = 1'b0;
	logic          arst_n = 1'b1;
	logic          req_valid = 1'b0;
	logic          req_ready;
	cba_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	cba_pkg::rsp_t rsp;

	// model of the allocator state
	bit         blk_free [NUM_BLOCKS];
	logic [7:0] dir_name [NUM_ENTRIES];
	int         dir_size [NUM_ENTRIES];
	int         dir_start[NUM_ENTRIES];
	bit         dir_live [NUM_ENTRIES];
	int         dir_used;

	cba_pkg::rsp_t expected_rsp[$];
	int   mismatches = 0;
	int   cycles = 0;
	int   transfers_in = 0;
	int   status_seen[5];

	// idling controls for sender and receiver
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;

	typedef struct {
		cba_pkg::req_t r;
		bit            fixed;
		cba_pkg::rsp_t exp;
	} stim_row_t;

	contiguous_block_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// clock and cycle limit
	initial begin
		forever begin
			#4 clk = ~clk;
			if (clk) begin
				cycles++;
				if (cycles > CYCLE_LIMIT) begin
					$display("timeout after %0d cycles", cycles);
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	function automatic void mark_run(int first, int len, bit val);
		for (int i = 0; i < len; i++)
			if (first + i < NUM_BLOCKS)
				blk_free[first + i] = val;
	endfunction

	// lowest start of a free run, -1 when none fits
	function automatic int first_fit(int len);
		int run;
		run = 0;
		if (len == 0)
			return 0;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			if (blk_free[i]) begin
				run++;
				if (run == len)
					return i + 1 - len;
			end else begin
				run = 0;
			end
		end
		return -1;
	endfunction

	function automatic int find_file(logic [7:0] name);
		for (int i = 0; i < dir_used; i++)
			if (dir_live[i] && dir_name[i] == name)
				return i;
		return -1;
	endfunction

	function automatic void reset_allocation();
		for (int i = 0; i < NUM_BLOCKS; i++)
			blk_free[i] = 1'b1;
		blk_free[0] = 1'b0;
		for (int i = 0; i < NUM_ENTRIES; i++)
			dir_live[i] = 1'b0;
		dir_used = 0;
	endfunction

	// applies one request to the model and returns its response
	function automatic cba_pkg::rsp_t allocate_step(cba_pkg::req_t r);
		cba_pkg::rsp_t o;
		int e, where, cnt, os, ol;
		o = '0;
		o.status = cba_pkg::ST_OK;
		cnt = int'(r.block_count);
		e = find_file(r.file_name);
		if (r.opcode == cba_pkg::OP_CREATE) begin
			where = first_fit(cnt);
			if (e >= 0) begin
				o.status = cba_pkg::ST_DUP;
			end else if (dir_used >= NUM_ENTRIES) begin
				o.status = cba_pkg::ST_DIRFULL;
			end else if (where < 0) begin
				o.status = cba_pkg::ST_NOSPACE;
			end else begin
				mark_run(where, cnt, 1'b0);
				dir_name[dir_used] = r.file_name;
				dir_size[dir_used] = cnt;
				dir_start[dir_used] = where;
				dir_live[dir_used] = 1'b1;
				dir_used++;
				o.start_block = where[7:0];
				o.length_blocks = cnt[7:0];
			end
		end else if (e < 0) begin
			o.status = cba_pkg::ST_NOTFOUND;
		end else begin
			os = dir_start[e];
			ol = dir_size[e];
			if (r.opcode == cba_pkg::OP_MODIFY) begin
				if (cnt <= ol) begin
					// truncate in place
					mark_run(os + cnt, ol - cnt, 1'b1);
					dir_size[e] = cnt;
					o.start_block = os[7:0];
					o.length_blocks = cnt[7:0];
				end else begin
					// old run is released before the search
					mark_run(os, ol, 1'b1);
					where = first_fit(cnt);
					if (where >= 0) begin
						mark_run(where, cnt, 1'b0);
						dir_start[e] = where;
						dir_size[e] = cnt;
						o.start_block = where[7:0];
						o.length_blocks = cnt[7:0];
					end else begin
						mark_run(os, ol, 1'b0);
						o.status = cba_pkg::ST_NOSPACE;
					end
				end
			end else if (r.opcode == cba_pkg::OP_DELETE) begin
				mark_run(os, ol, 1'b1);
				dir_size[e] = 0;
				dir_start[e] = 0;
				dir_live[e] = 1'b0;
			end else begin
				o.start_block = os[7:0];
				o.length_blocks = ol[7:0];
			end
		end
		return o;
	endfunction

	function automatic cba_pkg::req_t random_request();
		cba_pkg::req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			r.opcode = cba_pkg::OP_CREATE;
		else if (pick < 60)
			r.opcode = cba_pkg::OP_MODIFY;
		else if (pick < 80)
			r.opcode = cba_pkg::OP_DELETE;
		else
			r.opcode = cba_pkg::OP_QUERY;
		// mostly a small pool of names so files are found again
		if ($urandom_range(99) < 70)
			r.file_name = 8'h40 + 8'($urandom_range(31));
		else
			r.file_name = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 20)
			r.block_count = 8'd0;
		else if (pick < 80)
			r.block_count = 8'($urandom_range(12, 1));
		else if (pick < 95)
			r.block_count = 8'($urandom_range(80, 13));
		else
			r.block_count = 8'($urandom_range(255));
		return r;
	endfunction

	// offers one request and waits for its transfer
	task automatic send_request(cba_pkg::req_t r, bit fixed, cba_pkg::rsp_t exp);
		cba_pkg::rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = allocate_step(r);
		expected_rsp.push_back(fixed ? exp : predicted);
		transfers_in++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp.size() > 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		mismatches++;
	endtask

	// receiver: random stalls, plus a long hold-off counted down here
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				rsp_ready <= 1'b0;
				hold_len--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		cba_pkg::rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected transfer, status", int'(rsp.status), -1);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status != want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.start_block != want.start_block)
					report_mismatch("start_block", int'(rsp.start_block),
						int'(want.start_block));
				if (rsp.length_blocks != want.length_blocks)
					report_mismatch("length_blocks", int'(rsp.length_blocks),
						int'(want.length_blocks));
				if (rsp.status <= cba_pkg::ST_DUP)
					status_seen[rsp.status]++;
			end
		end
	end

	stim_row_t dir_rows[] = '{
		// empty directory: nothing to find
		'{'{cba_pkg::OP_QUERY,  8'h05, 8'd0},   1, '{cba_pkg::ST_NOTFOUND, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_MODIFY, 8'h05, 8'd9},   1, '{cba_pkg::ST_NOTFOUND, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_DELETE, 8'h05, 8'd0},   1, '{cba_pkg::ST_NOTFOUND, 8'd0, 8'd0}},
		// block zero is reserved, first file lands at one
		'{'{cba_pkg::OP_CREATE, 8'h41, 8'd10},  1, '{cba_pkg::ST_OK, 8'd1, 8'd10}},
		'{'{cba_pkg::OP_CREATE, 8'h41, 8'd3},   1, '{cba_pkg::ST_DUP, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_CREATE, 8'h00, 8'd0},   1, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_CREATE, 8'hFF, 8'd255}, 1, '{cba_pkg::ST_NOSPACE, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_CREATE, 8'h2A, 8'd5},   1, '{cba_pkg::ST_OK, 8'd11, 8'd5}},
		'{'{cba_pkg::OP_QUERY,  8'h41, 8'd0},   1, '{cba_pkg::ST_OK, 8'd1, 8'd10}},
		'{'{cba_pkg::OP_MODIFY, 8'h41, 8'd4},   1, '{cba_pkg::ST_OK, 8'd1, 8'd4}},
		'{'{cba_pkg::OP_MODIFY, 8'h41, 8'd0},   1, '{cba_pkg::ST_OK, 8'd1, 8'd0}},
		'{'{cba_pkg::OP_MODIFY, 8'h41, 8'd20},  0, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_MODIFY, 8'h2A, 8'd255}, 1, '{cba_pkg::ST_NOSPACE, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_DELETE, 8'h2A, 8'd7},   1, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_CREATE, 8'h2A, 8'd200}, 0, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_MODIFY, 8'h00, 8'd3},   0, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_QUERY,  8'h00, 8'd0},   0, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_MODIFY, 8'h41, 8'd30},  0, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_DELETE, 8'h41, 8'd0},   1, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_QUERY,  8'h41, 8'd0},   1, '{cba_pkg::ST_NOTFOUND, 8'd0, 8'd0}},
		// a deleted name comes back in a new slot
		'{'{cba_pkg::OP_CREATE, 8'h41, 8'd1},   0, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_CREATE, 8'h23, 8'd255}, 0, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_DELETE, 8'h2A, 8'd0},   0, '{cba_pkg::ST_OK, 8'd0, 8'd0}},
		'{'{cba_pkg::OP_CREATE, 8'h23, 8'd255}, 0, '{cba_pkg::ST_OK, 8'd0, 8'd0}}
	};

	// main sequence
	initial begin
		reset_allocation();
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, no idling
		foreach (dir_rows[i])
			send_request(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].exp);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 62;
					// long hold-off so the input side backs up
					hold_len = HOLD_CYCLES;
				end
				default: begin
					send_idle_pct = 11;
					recv_stall_pct = 11;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request(), 1'b0, '0);
			// sender pauses until every response is back
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d request transfers, %0d directory slots used", transfers_in, dir_used);
		$display("responses ok %0d, no space %0d, not found %0d, dir full %0d, duplicate %0d",
			status_seen[cba_pkg::ST_OK], status_seen[cba_pkg::ST_NOSPACE],
			status_seen[cba_pkg::ST_NOTFOUND], status_seen[cba_pkg::ST_DIRFULL],
			status_seen[cba_pkg::ST_DUP]);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches, expected_rsp.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
